// ----- sv/fraction_arith_reduce_top_macros.svh -----
// Shared assertion macros for the fraction reducer checks.
`ifndef FRACTION_ARITH_REDUCE_TOP_MACROS_SVH
`define FRACTION_ARITH_REDUCE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FAR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fraction reducer check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define FAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fraction reducer check failed");

`endif

// ----- sv/far_pkg.sv -----
package far_pkg;

  localparam int WIDTH     = 16;
  localparam int MAG_W     = WIDTH + 1;
  localparam int PROD_W    = 2 * WIDTH;
  localparam int SUM_W     = 2 * WIDTH + 1;
  localparam int K_W       = $clog2(SUM_W + 1);
  localparam int CNT_W     = $clog2(SUM_W);
  localparam int NUM_OUT_W = 33;
  localparam int DEN_OUT_W = 31;
  localparam int EXT_N_W   = (SUM_W > NUM_OUT_W) ? SUM_W : NUM_OUT_W;
  localparam int EXT_D_W   = (SUM_W > DEN_OUT_W) ? SUM_W : DEN_OUT_W;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  typedef enum logic [1:0] {
    MSEL_NUM,
    MSEL_DEN,
    MSEL_CROSS
  } mul_sel_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [WIDTH-1:0] left_numerator;
    logic signed [WIDTH-1:0] left_denominator;
    logic signed [WIDTH-1:0] right_numerator;
    logic signed [WIDTH-1:0] right_denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [NUM_OUT_W-1:0] result_numerator;
    logic [DEN_OUT_W-1:0]        result_denominator;
    logic                        error_code;
  } out_item_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     combine;
    logic     gcd_step;
    logic     scale;
    logic     div_step;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic bad;
    logic addsub;
    logic num_zero;
    logic gcd_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [MAG_W-1:0] field_mag(input logic signed [WIDTH-1:0] v);
    logic [MAG_W-1:0] ext;
    ext = {v[WIDTH-1], v};
    return v[WIDTH-1] ? (~ext + 1'b1) : ext;
  endfunction

endpackage

// ----- sv/far_ctrl.sv -----
module far_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  far_pkg::dp_stat_t  stat,
  output far_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_MUL_NUM   = 9'b000000010,
    S_MUL_DEN   = 9'b000000100,
    S_MUL_CROSS = 9'b000001000,
    S_COMBINE   = 9'b000010000,
    S_GCD       = 9'b000100000,
    S_SCALE     = 9'b001000000,
    S_DIVIDE    = 9'b010000000,
    S_FINISH    = 9'b100000000
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [far_pkg::CNT_W-1:0]  cnt;
  logic [far_pkg::CNT_W-1:0]  cnt_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL_NUM;
        end
      end
      S_MUL_NUM: begin
        if (stat.bad) begin
          state_next = S_FINISH;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = far_pkg::MSEL_NUM;
          state_next  = S_MUL_DEN;
        end
      end
      S_MUL_DEN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = far_pkg::MSEL_DEN;
        state_next  = stat.addsub ? S_MUL_CROSS : S_COMBINE;
      end
      S_MUL_CROSS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = far_pkg::MSEL_CROSS;
        state_next  = S_COMBINE;
      end
      S_COMBINE: begin
        cmd.combine = 1'b1;
        state_next  = S_GCD;
      end
      S_GCD: begin
        if (stat.num_zero) begin
          state_next = S_FINISH;
        end else if (stat.gcd_done) begin
          state_next = S_SCALE;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        cnt_next   = '0;
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (cnt == far_pkg::CNT_W'(far_pkg::SUM_W - 1)) begin
          state_next = S_FINISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ----- sv/far_datapath.sv -----
module far_datapath (
  input  logic               clk,
  input  logic               rst,
  input  far_pkg::in_item_t  in_item,
  input  far_pkg::ctl_cmd_t  cmd,
  output far_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_stall,
  output far_pkg::out_item_t out_item
);

  logic [1:0]                  kind;
  logic [far_pkg::MAG_W-1:0]   ln_mag, ld_mag, rn_mag, rd_mag;
  logic                        ln_neg, ld_neg, rn_neg, rd_neg;
  logic [far_pkg::PROD_W-1:0]  t1, t2, den;
  logic                        t1_neg, t2_neg, den_neg;
  logic [far_pkg::SUM_W-1:0]   num;
  logic                        num_neg;
  logic [far_pkg::SUM_W-1:0]   ga, gb, g;
  logic [far_pkg::K_W-1:0]     gk;
  logic [far_pkg::SUM_W-1:0]   nq, dq, nr, dr;

  logic [far_pkg::MAG_W-1:0]   op_a, op_b;
  logic                        prod_neg;
  logic [2*far_pkg::MAG_W-1:0] prod_full;
  logic [far_pkg::PROD_W-1:0]  prod;

  logic [far_pkg::SUM_W-1:0]   t1_ext, t2_ext, sum;
  logic                        sum_neg;

  logic [far_pkg::SUM_W-1:0]   ga_next, gb_next;
  logic [far_pkg::K_W-1:0]     gk_next;

  logic [far_pkg::SUM_W:0]     n_rs, d_rs, g_ext;
  logic                        n_ge, d_ge;
  logic [far_pkg::SUM_W:0]     n_rem, d_rem;

  logic                        res_neg;
  logic [far_pkg::EXT_N_W-1:0] n_ext, n_sgn;
  logic [far_pkg::EXT_D_W-1:0] d_ext;
  far_pkg::out_item_t          res;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind   <= in_item.kind;
      ln_mag <= far_pkg::field_mag(in_item.left_numerator);
      ld_mag <= far_pkg::field_mag(in_item.left_denominator);
      rn_mag <= far_pkg::field_mag(in_item.right_numerator);
      rd_mag <= far_pkg::field_mag(in_item.right_denominator);
      ln_neg <= in_item.left_numerator[far_pkg::WIDTH-1];
      ld_neg <= in_item.left_denominator[far_pkg::WIDTH-1];
      rn_neg <= in_item.right_numerator[far_pkg::WIDTH-1];
      rd_neg <= in_item.right_denominator[far_pkg::WIDTH-1];
    end
  end

  always_comb begin
    op_a     = '0;
    op_b     = '0;
    prod_neg = 1'b0;
    case (cmd.mul_sel)
      far_pkg::MSEL_NUM: begin
        op_a = ln_mag;
        if (kind == far_pkg::KIND_MUL) begin
          op_b     = rn_mag;
          prod_neg = ln_neg ^ rn_neg;
        end else begin
          op_b     = rd_mag;
          prod_neg = ln_neg ^ rd_neg;
        end
      end
      far_pkg::MSEL_DEN: begin
        op_a = ld_mag;
        if (kind == far_pkg::KIND_DIV) begin
          op_b     = rn_mag;
          prod_neg = ld_neg ^ rn_neg;
        end else begin
          op_b     = rd_mag;
          prod_neg = ld_neg ^ rd_neg;
        end
      end
      far_pkg::MSEL_CROSS: begin
        op_a     = ld_mag;
        op_b     = rn_mag;
        prod_neg = ld_neg ^ rn_neg ^ (kind == far_pkg::KIND_SUB);
      end
      default: begin
        op_a     = '0;
        op_b     = '0;
        prod_neg = 1'b0;
      end
    endcase
  end

  assign prod_full = op_a * op_b;
  assign prod      = prod_full[far_pkg::PROD_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        far_pkg::MSEL_NUM: begin
          t1     <= prod;
          t1_neg <= prod_neg;
        end
        far_pkg::MSEL_DEN: begin
          den     <= prod;
          den_neg <= prod_neg;
        end
        far_pkg::MSEL_CROSS: begin
          t2     <= prod;
          t2_neg <= prod_neg;
        end
        default: begin
          t1 <= t1;
        end
      endcase
    end
  end

  assign t1_ext = far_pkg::SUM_W'(t1);
  assign t2_ext = far_pkg::SUM_W'(t2);

  always_comb begin
    if (!stat.addsub) begin
      sum     = t1_ext;
      sum_neg = t1_neg;
    end else if (t1_neg == t2_neg) begin
      sum     = t1_ext + t2_ext;
      sum_neg = t1_neg;
    end else if (t1_ext >= t2_ext) begin
      sum     = t1_ext - t2_ext;
      sum_neg = t1_neg;
    end else begin
      sum     = t2_ext - t1_ext;
      sum_neg = t2_neg;
    end
  end

  always_comb begin
    ga_next = ga;
    gb_next = gb;
    gk_next = gk;
    if (!ga[0] && !gb[0]) begin
      ga_next = ga >> 1;
      gb_next = gb >> 1;
      gk_next = gk + 1'b1;
    end else if (!ga[0]) begin
      ga_next = ga >> 1;
    end else if (!gb[0]) begin
      gb_next = gb >> 1;
    end else if (ga >= gb) begin
      ga_next = (ga - gb) >> 1;
    end else begin
      gb_next = (gb - ga) >> 1;
    end
  end

  assign g_ext = {1'b0, g};
  assign n_rs  = {nr, nq[far_pkg::SUM_W-1]};
  assign d_rs  = {dr, dq[far_pkg::SUM_W-1]};
  assign n_ge  = (n_rs >= g_ext);
  assign d_ge  = (d_rs >= g_ext);
  assign n_rem = n_ge ? (n_rs - g_ext) : n_rs;
  assign d_rem = d_ge ? (d_rs - g_ext) : d_rs;

  always_ff @(posedge clk) begin
    if (cmd.combine) begin
      num     <= sum;
      num_neg <= sum_neg;
      ga      <= sum;
      gb      <= far_pkg::SUM_W'(den);
      gk      <= '0;
    end else if (cmd.gcd_step) begin
      ga <= ga_next;
      gb <= gb_next;
      gk <= gk_next;
    end
    if (cmd.scale) begin
      g  <= (ga | gb) << gk;
      nq <= num;
      dq <= far_pkg::SUM_W'(den);
      nr <= '0;
      dr <= '0;
    end else if (cmd.div_step) begin
      nr <= n_rem[far_pkg::SUM_W-1:0];
      dr <= d_rem[far_pkg::SUM_W-1:0];
      nq <= {nq[far_pkg::SUM_W-2:0], n_ge};
      dq <= {dq[far_pkg::SUM_W-2:0], d_ge};
    end
  end

  assign res_neg = num_neg ^ den_neg;
  assign n_ext   = far_pkg::EXT_N_W'(nq);
  assign n_sgn   = res_neg ? (~n_ext + 1'b1) : n_ext;
  assign d_ext   = far_pkg::EXT_D_W'(dq);

  always_comb begin
    if (stat.bad) begin
      res.result_numerator   = '0;
      res.result_denominator = '0;
      res.error_code         = 1'b1;
    end else if (stat.num_zero) begin
      res.result_numerator   = '0;
      res.result_denominator = far_pkg::DEN_OUT_W'(1);
      res.error_code         = 1'b0;
    end else begin
      res.result_numerator   = $signed(n_sgn[far_pkg::NUM_OUT_W-1:0]);
      res.result_denominator = d_ext[far_pkg::DEN_OUT_W-1:0];
      res.error_code         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item <= res;
    end
  end

  assign stat.bad      = (ld_mag == '0) || (rd_mag == '0) ||
                         ((kind == far_pkg::KIND_DIV) && (rn_mag == '0));
  assign stat.addsub   = (kind == far_pkg::KIND_ADD) || (kind == far_pkg::KIND_SUB);
  assign stat.num_zero = (num == '0);
  assign stat.gcd_done = (ga == '0) || (gb == '0);
  assign stat.out_free = !out_valid || !out_stall;

endmodule

// ----- sv/fraction_arith_reduce_top.sv -----
// Signed fraction add, subtract, multiply and divide with the result reduced to lowest
// terms and the sign carried on the numerator. One item is worked at a time; a new item
// is taken while the previous result still waits in the output register. An item passes
// through a load, two or three products on the shared multiplier, a combine, the binary
// GCD loop (one shift or subtract-and-shift per cycle, data dependent), a scale step that
// forms the divisor, and a restoring division that divides numerator and denominator by
// the GCD side by side. A zero denominator, or a divide by a zero numerator, returns 0/0
// with error_code set; a zero result returns 0/1 without the GCD and division passes.
module fraction_arith_reduce_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  far_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output far_pkg::out_item_t out_item
);

  far_pkg::ctl_cmd_t cmd;
  far_pkg::dp_stat_t stat;

  far_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  far_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- sv/far_checker.sv -----
`include "fraction_arith_reduce_top_macros.svh"

module far_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input far_pkg::out_item_t out_item
);

  `FAR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `FAR_ASSERT_NOW(a_error_zeroes, out_valid && out_item.error_code, (out_item.result_numerator == '0) && (out_item.result_denominator == '0))
  `FAR_ASSERT_NOW(a_den_nonzero, out_valid && !out_item.error_code, out_item.result_denominator != '0)
  `FAR_ASSERT_NOW(a_zero_is_unit, out_valid && !out_item.error_code && (out_item.result_numerator == '0), out_item.result_denominator == 31'd1)
  `FAR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

endmodule

bind fraction_arith_reduce_top far_checker u_far_checker (.*);
